[hw/rtl/l2hist_pkg.sv]
package l2hist_pkg;

    localparam int SAMPLE_W = 64;
    localparam int IDX_W    = 6;
    localparam int COUNT_W  = 32;
    localparam int IN_W     = 72;   // sample_value + read_bin, padded to bytes
    localparam int OUT_W    = 296;  // all result fields, padded to bytes

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [SAMPLE_W-1:0] MIN_RESET = {SAMPLE_W{1'b1}};
    localparam logic [SAMPLE_W-1:0] MAX_RESET = '0;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    // Index of the highest set bit; 0 and 1 both give 0.
    function automatic logic [IDX_W-1:0] top_bit_index(input logic [SAMPLE_W-1:0] x);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int b = 1; b < SAMPLE_W; b++) begin
            if (x[b])
            begin
                idx = IDX_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

[hw/rtl/log2_histogram_min_max_sum_core.sv]
// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+---------------------------------------
// s_axis    | in        | s_axis_tvalid/s_axis_tready | tuser: op; tdata: sample, read_bin
// m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata: bin, count, min, max, sum, events
//
// Each request passes through three steps: accept, bin lookup with a bin store read, then
// read-modify-write of the bin counter and the running statistics.
// The bin store read is registered, so the lookup and the update are separate steps.
// Reset clears the bin store at once through per-bin valid bits; no clearing pass.
// A result waits in the output register; the next request is accepted meanwhile,
// and the update step holds while the output register is still full.
module log2_histogram_min_max_sum_core
    import l2hist_pkg::*;
#(
    parameter int NUM_BINS = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // [63:0] sample_value, [69:64] read_bin, pad
    input  logic [0:0]       s_axis_tuser,   // [0] op
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // [5:0] bin_index, [37:6] bin_count,
                                             // [101:38] running_min, [165:102] running_max,
                                             // [229:166] running_sum, [293:230] event_count
);

    localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [IDX_W:0] LAST_BIN = (IDX_W + 1)'(NUM_BINS - 1);

    state_t state_reg, state_next;

    logic                op_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [IDX_W-1:0]    read_bin_reg;
    logic [IDX_W-1:0]    bin_reg;

    logic [SAMPLE_W-1:0] min_reg, max_reg, sum_reg, cnt_reg;
    logic [SAMPLE_W-1:0] min_next, max_next, sum_next, cnt_next;

    logic [COUNT_W-1:0]  mem [NUM_BINS];
    logic [COUNT_W-1:0]  mem_q;
    logic [NUM_BINS-1:0] bin_valid_reg;
    logic                valid_q_reg;

    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    logic [IDX_W-1:0]    raw_bin;
    logic [IDX_W-1:0]    bin_next;
    logic [COUNT_W-1:0]  cur_count, new_count;
    logic                accept, advance;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign advance       = (state_reg == ST_UPD) && (!m_tvalid_reg || m_axis_tready);

    // Bin from the highest set bit, or from the request, clamped to the last bin
    assign raw_bin  = (op_reg == OP_READ) ? read_bin_reg : top_bit_index(sample_reg);
    assign bin_next = ({1'b0, raw_bin} > LAST_BIN) ? IDX_W'(LAST_BIN) : raw_bin;

    assign cur_count = valid_q_reg ? mem_q : '0;
    assign new_count = (op_reg == OP_RECORD) ? cur_count + COUNT_W'(1) : cur_count;

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (op_reg == OP_RECORD)
        begin
            if (sample_reg < min_reg)
            begin
                min_next = sample_reg;
            end
            if (sample_reg > max_reg)
            begin
                max_next = sample_reg;
            end
            sum_next = sum_reg + sample_reg;
            cnt_next = cnt_reg + SAMPLE_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            min_reg       <= MIN_RESET;
            max_reg       <= MAX_RESET;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            bin_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (advance)
            begin
                min_reg <= min_next;
                max_reg <= max_next;
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
                bin_valid_reg[bin_reg[BIN_W-1:0]] <= 1'b1;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= s_axis_tuser[0];
            sample_reg   <= s_axis_tdata[SAMPLE_W-1:0];
            read_bin_reg <= s_axis_tdata[SAMPLE_W +: IDX_W];
        end
        if (state_reg == ST_LOOK)
        begin
            bin_reg     <= bin_next;
            valid_q_reg <= bin_valid_reg[bin_next[BIN_W-1:0]];
        end
        if (advance)
        begin
            m_tdata_reg <= {2'b00, cnt_next, sum_next, max_next, min_next, new_count, bin_reg};
        end
    end

    // Bin store: read in the lookup step, write back in the update step
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mem[bin_reg[BIN_W-1:0]] <= new_count;
        end
        if (state_reg == ST_LOOK)
        begin
            mem_q <= mem[bin_next[BIN_W-1:0]];
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && op_reg == OP_RECORD) |=> (cnt_reg == $past(cnt_reg) + SAMPLE_W'(1)))
        else $error("event count did not advance by one on a record");

    a_read_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && op_reg == OP_READ) |=> ($stable(sum_reg) && $stable(cnt_reg)))
        else $error("read request changed the statistics");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (min_reg <= max_reg))
        else $error("running minimum above running maximum");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_axis_tready) |-> !advance)
        else $error("pending result overwritten");

endmodule
